@@ rtl/wsd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsd_pkg;

    localparam int unsigned LEN_BITS_DEF = 16;
    localparam int unsigned CFG_W        = 17;
    localparam int unsigned BYTE_W       = 8;

    // Reset value of the payload limit; zero also means "no limit below 64 KiB"
    localparam logic [CFG_W-1:0] MAX_PAYLOAD_RST = 17'h10000;

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_LEN64    = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last;
        t_status           status;
    } t_result;

endpackage

@@ rtl/wsd_parser.sv @@
// Frame header parser and payload unmasking: one byte in, at most one result out.
// Depends on wsd_pkg.
module wsd_parser #(
    parameter int unsigned LEN_BITS = wsd_pkg::LEN_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [7:0]                i_byte,
    input  logic [wsd_pkg::CFG_W-1:0] i_limit,
    output logic                      o_res_valid,
    output wsd_pkg::t_result          o_res
);
    import wsd_pkg::*;

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXT_HI  = 6'b000100,
        PH_EXT_LO  = 6'b001000,
        PH_KEY     = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [1:0]          r_key_idx, n_key_idx;
    logic                r_masked, n_masked;
    logic [LEN_BITS-1:0] r_frame_len, n_frame_len;
    logic [LEN_BITS-1:0] r_byte_cnt, n_byte_cnt;
    logic [7:0]          r_ext_hi, n_ext_hi;
    logic [7:0]          r_key [4];

    logic [15:0]         w_len;
    logic                w_over;
    logic [7:0]          w_key;
    logic [LEN_BITS-1:0] w_cnt_inc;
    logic                w_key_we;

    // Length candidate: short code on the second header byte, else the 16-bit field
    assign w_len = (r_phase == PH_HDR1) ? {9'd0, i_byte[6:0]} : {r_ext_hi, i_byte};
    assign w_over = ((w_len >> LEN_BITS) != 16'd0) ||
                    ((i_limit != '0) && ({1'b0, w_len} > i_limit));
    assign w_key     = r_masked ? r_key[r_byte_cnt[1:0]] : 8'd0;
    assign w_cnt_inc = r_byte_cnt + 1'b1;
    assign w_key_we  = i_valid && (r_phase == PH_KEY);

    always_comb begin
        n_phase     = r_phase;
        n_key_idx   = r_key_idx;
        n_masked    = r_masked;
        n_frame_len = r_frame_len;
        n_byte_cnt  = r_byte_cnt;
        n_ext_hi    = r_ext_hi;
        o_res_valid = 1'b0;
        o_res       = '{data_byte: 8'd0, last: 1'b1, status: ST_DATA};
        if (i_valid) begin
            unique case (r_phase)
                PH_HDR1, PH_EXT_LO: begin
                    if (r_phase == PH_HDR1) begin
                        n_masked = i_byte[7];
                    end
                    if ((r_phase == PH_HDR1) && (i_byte[6:0] == LEN_CODE_EXT64)) begin
                        n_phase      = PH_HDR0;
                        o_res_valid  = 1'b1;
                        o_res.status = ST_LEN64;
                    end else if ((r_phase == PH_HDR1) &&
                                 (i_byte[6:0] == LEN_CODE_EXT16)) begin
                        n_phase = PH_EXT_HI;
                    end else if (w_over) begin
                        n_phase      = PH_HDR0;
                        o_res_valid  = 1'b1;
                        o_res.status = ST_TOO_LONG;
                    end else begin
                        n_frame_len = w_len[LEN_BITS-1:0];
                        if (((r_phase == PH_HDR1) && i_byte[7]) ||
                            ((r_phase == PH_EXT_LO) && r_masked)) begin
                            n_key_idx = 2'd0;
                            n_phase   = PH_KEY;
                        end else if (w_len == 16'd0) begin
                            n_phase      = PH_HDR0;
                            o_res_valid  = 1'b1;
                            o_res.status = ST_EMPTY;
                        end else begin
                            n_byte_cnt = '0;
                            n_phase    = PH_PAYLOAD;
                        end
                    end
                end
                PH_EXT_HI: begin
                    n_ext_hi = i_byte;
                    n_phase  = PH_EXT_LO;
                end
                PH_KEY: begin
                    n_key_idx = r_key_idx + 2'd1;
                    if (r_key_idx == 2'd3) begin
                        if (r_frame_len == '0) begin
                            n_phase      = PH_HDR0;
                            o_res_valid  = 1'b1;
                            o_res.status = ST_EMPTY;
                        end else begin
                            n_byte_cnt = '0;
                            n_phase    = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_byte_cnt      = w_cnt_inc;
                    o_res_valid     = 1'b1;
                    o_res.data_byte = i_byte ^ w_key;
                    o_res.last      = (w_cnt_inc == r_frame_len);
                    if (w_cnt_inc == r_frame_len) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    // first header byte, and any stray encoding
                    n_phase = PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_key_idx   <= 2'd0;
            r_masked    <= 1'b0;
            r_frame_len <= '0;
            r_byte_cnt  <= '0;
        end else begin
            r_phase     <= n_phase;
            r_key_idx   <= n_key_idx;
            r_masked    <= n_masked;
            r_frame_len <= n_frame_len;
            r_byte_cnt  <= n_byte_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ext_hi <= n_ext_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= 8'd0;
            r_key[1] <= 8'd0;
            r_key[2] <= 8'd0;
            r_key[3] <= 8'd0;
        end else if (w_key_we) begin
            r_key[r_key_idx] <= i_byte;
        end
    end

    // a payload phase always has a non-empty frame to count through
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_frame_len != '0)
        else $error("payload phase with zero frame length");

    // the key phase only follows a masked header
    a_key_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_KEY |-> r_masked)
        else $error("key phase without mask flag");

    // the byte count never runs past the frame length
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_byte_cnt < r_frame_len)
        else $error("byte count overran frame length");

endmodule

@@ rtl/wsd_out_skid.sv @@
// Result register with one skid entry, decoupling the input handshake from output stalls.
// Depends on wsd_pkg.
module wsd_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wsd_pkg::t_result i_res,
    output logic             o_ready,
    output logic             o_valid,
    output wsd_pkg::t_result o_res,
    input  logic             i_pop_ready
);
    import wsd_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    w_pop;

    assign w_pop   = r_out_valid && i_pop_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_pop) begin
                n_out       = i_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end else if (w_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !w_pop |=> r_skid_valid && $stable(r_skid))
        else $error("skid entry lost or overwritten");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && w_pop |=> r_out_valid && !r_skid_valid)
        else $error("skid entry not moved to output on pop");

endmodule

@@ rtl/websocket_frame_deframer.sv @@
// WebSocket frame deframer: parses header, length, mask key and unmasks payload bytes.
// Output: each result is registered, in the output register or, while the output stalls, in the skid entry.
// Throughput: one byte per cycle; o_s_tready drops only while the skid entry holds a result.
// Reset: synchronous, active low; parser returns to the first header byte, limit to 65536.
// Depends on wsd_pkg, wsd_parser and wsd_out_skid.
module websocket_frame_deframer #(
    parameter int unsigned LEN_BITS = wsd_pkg::LEN_BITS_DEF  // 8..16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write channel: max_payload
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [wsd_pkg::CFG_W-1:0] i_cfg_data,    // [16:0] max_payload
    // byte stream in
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [7:0]                i_s_tdata,     // [7:0] rx_byte
    // results out
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [7:0]                o_m_tdata,     // [7:0] data_byte
    output logic                      o_m_tlast,     // last
    output logic [1:0]                o_m_tuser      // [1:0] status
);
    import wsd_pkg::*;

    logic [CFG_W-1:0] r_max_payload;
    logic             w_accept;
    logic             w_res_valid;
    t_result          w_res;
    t_result          w_out;

    // Limit register; a write is always taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            r_max_payload <= i_cfg_data;
        end
    end

    // A byte transaction completes whenever the skid entry is free.
    assign w_accept = i_s_tvalid && o_s_tready;

    // Header/payload state machine; all per-byte work is combinational here.
    wsd_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_byte      (i_s_tdata),
        .i_limit     (r_max_payload),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Result register plus skid entry, so one more result is taken while the output stalls.
    wsd_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res_valid),
        .i_res       (w_res),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .o_res       (w_out),
        .i_pop_ready (i_m_tready)
    );

    assign o_m_tdata = w_out.data_byte;
    assign o_m_tlast = w_out.last;
    assign o_m_tuser = w_out.status;

endmodule
